// ----- src/ippf_pkg.sv -----
// Shared types and constants for the IPv4 packet filter with pattern count.
package ippf_pkg;

   localparam int PATTERN_W       = 64;
   localparam int PATTERN_BYTES   = PATTERN_W / 8;
   localparam int LEN_CLAMP_W     = 5;
   localparam int OFFSET_W        = 16;
   localparam int COUNT_W         = 16;
   localparam int PSTART_W        = 7;
   localparam int IHB_W           = 6;

   localparam logic [7:0]          PROTO_TCP      = 8'd6;
   localparam logic [7:0]          PROTO_UDP      = 8'd17;
   localparam logic [PSTART_W-1:0] UDP_HDR_BYTES  = 7'd8;
   localparam logic [IHB_W-1:0]    MIN_HDR_BYTES  = 6'd20;
   localparam logic [OFFSET_W-1:0] OFS_PROTOCOL   = 16'd9;
   localparam logic [OFFSET_W-1:0] OFS_SRC_FIRST  = 16'd12;
   localparam logic [OFFSET_W-1:0] OFS_SRC_LAST   = 16'd15;
   localparam logic [OFFSET_W-1:0] OFS_TRANSPORT  = 16'd20;
   localparam logic [OFFSET_W-1:0] OFS_TCP_DOFF   = 16'd12;
   localparam logic [OFFSET_W-1:0] OFFSET_MAX     = 16'hFFFF;
   localparam logic [COUNT_W-1:0]  COUNT_MAX      = 16'hFFFF;

   typedef enum logic [1:0] {
      CSR_MATCH_ADDRESS = 2'd0,
      CSR_MATCH_PORT    = 2'd1,
      CSR_PATTERN_BYTES = 2'd2,
      CSR_PATTERN_LEN   = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      VERDICT_SELECTED      = 3'd0,
      VERDICT_ADDR_MISMATCH = 3'd1,
      VERDICT_PROTO_PORT    = 3'd2,
      VERDICT_PATTERN_ABSENT = 3'd3,
      VERDICT_TRUNCATED     = 3'd4
   } verdict_type;

   typedef struct packed {
      logic [7:0] pkt_byte;
      logic       end_of_packet;
   } req_type;

   typedef struct packed {
      verdict_type        verdict;
      logic [COUNT_W-1:0] appearances;
   } rsp_type;

endpackage

// ----- src/ip_packet_filter_pattern_count_unit.sv -----
// IPv4 packet filter: header parse, address/port select and payload pattern count.
//
// Usage:
//   req_ carries one packet byte per beat with an end-of-packet flag, header first.
//   rsp_ carries one beat per packet: a verdict and the payload pattern count,
//   presented the cycle after the final byte of the packet is accepted.
//   csr_ writes the match address, match port, pattern bytes and pattern length;
//   write only while no packet is in flight and no result is pending.
// Throughput: one byte per cycle while req_ready is high. Each beat is parsed
// in the cycle it is accepted; a payload beat is also shifted into the window
// and compared in that cycle; the result register holds the verdict.
// Stall: while a result waits and rsp_ready is low, req_ready drops; one result
// register decouples the sides, so bytes keep flowing whenever the slot drains.
// Reset: synchronous, active high; registers return to address 0, port 0,
// pattern 0, length 1; packet state clears and no result is pending.
// After each final byte the packet state clears; the registers keep their values.
module ip_packet_filter_pattern_count_unit #(
   parameter int MAX_PATTERN = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  ippf_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output ippf_pkg::rsp_type               rsp_data,
   input  logic                            csr_write_en,
   input  logic [1:0]                      csr_index,
   input  logic [ippf_pkg::PATTERN_W-1:0]  csr_wdata
);
   import ippf_pkg::*;

   localparam int SEEN_W = $clog2(MAX_PATTERN + 1);
   localparam logic [SEEN_W-1:0]      SEEN_MAX  = SEEN_W'(MAX_PATTERN);
   localparam logic [LEN_CLAMP_W-1:0] LEN_LIMIT = LEN_CLAMP_W'(MAX_PATTERN);

   logic [31:0]               match_address_ff;
   logic [15:0]               match_port_ff;
   logic [PATTERN_W-1:0]      pattern_ff;
   logic [3:0]                pattern_len_ff;

   logic [OFFSET_W-1:0]       byte_offset_ff, byte_offset_in;
   logic [IHB_W-1:0]          ihb_ff, ihb_in;
   logic [7:0]                proto_ff, proto_in;
   logic [31:0]               src_addr_ff, src_addr_in;
   logic [15:0]               src_port_ff, src_port_in;
   logic [PSTART_W-1:0]       pstart_ff, pstart_in;
   logic [MAX_PATTERN-1:0][7:0] recent_ff, recent_in;
   logic [SEEN_W-1:0]         seen_ff, seen_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   logic                      accept;
   logic [IHB_W-1:0]          ihb_cur;
   logic [7:0]                proto_cur;
   logic [31:0]               src_addr_cur;
   logic [15:0]               src_port_cur;
   logic [PSTART_W-1:0]       pstart_cur;
   logic [MAX_PATTERN-1:0][7:0] window_new;
   logic [SEEN_W-1:0]         seen_new;
   logic [SEEN_W-1:0]         len_eff;
   logic [COUNT_W-1:0]        count_cur;
   logic                      take;
   logic                      hit;
   verdict_type               verdict;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      logic [LEN_CLAMP_W-1:0] len_w;
      len_w = LEN_CLAMP_W'(pattern_len_ff);
      if (len_w == '0) begin
         len_eff = SEEN_W'(1);
      end else if (len_w > LEN_LIMIT) begin
         len_eff = SEEN_MAX;
      end else begin
         len_eff = len_w[SEEN_W-1:0];
      end
   end

   always_comb begin
      logic [7:0]          b;
      logic [OFFSET_W-1:0] o;
      logic [OFFSET_W-1:0] ihb_ext;
      logic [IHB_W-1:0]    th;
      b = req_data.pkt_byte;
      o = byte_offset_ff;

      ihb_cur = ihb_ff;
      if (o == '0) begin
         ihb_cur = {b[3:0], 2'b00};
         if (ihb_cur < MIN_HDR_BYTES) begin
            ihb_cur = MIN_HDR_BYTES;
         end
      end
      ihb_ext = OFFSET_W'(ihb_cur);

      proto_cur  = proto_ff;
      pstart_cur = pstart_ff;
      if (o == OFS_PROTOCOL) begin
         proto_cur = b;
         if (b == PROTO_UDP) begin
            pstart_cur = PSTART_W'(ihb_cur) + UDP_HDR_BYTES;
         end
      end

      src_addr_cur = src_addr_ff;
      if (o >= OFS_SRC_FIRST && o <= OFS_SRC_LAST) begin
         src_addr_cur = {src_addr_ff[23:0], b};
      end

      src_port_cur = src_port_ff;
      th = {b[7:4], 2'b00};
      if (th < MIN_HDR_BYTES) begin
         th = MIN_HDR_BYTES;
      end
      if (o >= OFS_TRANSPORT) begin
         if (o == ihb_ext || o == ihb_ext + OFFSET_W'(1)) begin
            src_port_cur = {src_port_ff[7:0], b};
         end
         if (proto_cur == PROTO_TCP && o == ihb_ext + OFS_TCP_DOFF) begin
            pstart_cur = PSTART_W'(ihb_cur) + PSTART_W'(th);
         end
      end

      take = (pstart_cur != '0) && (o >= OFFSET_W'(pstart_cur));

      window_new[0] = b;
      for (int k = 1; k < MAX_PATTERN; k++) begin
         window_new[k] = recent_ff[k-1];
      end
      seen_new = (seen_ff < SEEN_MAX) ? seen_ff + SEEN_W'(1) : seen_ff;
   end

   ippf_match #(
      .MAX_PATTERN (MAX_PATTERN),
      .SEEN_W      (SEEN_W)
   ) u_match (
      .window  (window_new),
      .seen    (seen_new),
      .pat_len (len_eff),
      .pattern (pattern_ff),
      .hit     (hit)
   );

   always_comb begin
      logic [OFFSET_W:0] pkt_len;
      count_cur = count_ff;
      if (take && hit && count_ff != COUNT_MAX) begin
         count_cur = count_ff + COUNT_W'(1);
      end

      pkt_len = {1'b0, byte_offset_ff} + (OFFSET_W+1)'(1);
      if (pkt_len < (OFFSET_W+1)'(MIN_HDR_BYTES)) begin
         verdict = VERDICT_TRUNCATED;
      end else if (src_addr_cur != match_address_ff) begin
         verdict = VERDICT_ADDR_MISMATCH;
      end else if (proto_cur != PROTO_TCP && proto_cur != PROTO_UDP) begin
         verdict = VERDICT_PROTO_PORT;
      end else if (pstart_cur == '0 || pkt_len < (OFFSET_W+1)'(pstart_cur)) begin
         verdict = VERDICT_TRUNCATED;
      end else if (src_port_cur != match_port_ff) begin
         verdict = VERDICT_PROTO_PORT;
      end else if (count_cur == '0) begin
         verdict = VERDICT_PATTERN_ABSENT;
      end else begin
         verdict = VERDICT_SELECTED;
      end
   end

   always_comb begin
      byte_offset_in = byte_offset_ff;
      ihb_in         = ihb_ff;
      proto_in       = proto_ff;
      src_addr_in    = src_addr_ff;
      src_port_in    = src_port_ff;
      pstart_in      = pstart_ff;
      recent_in      = recent_ff;
      seen_in        = seen_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      if (accept) begin
         if (take) begin
            recent_in = window_new;
         end
         if (req_data.end_of_packet) begin
            byte_offset_in = '0;
            ihb_in         = '0;
            proto_in       = '0;
            src_addr_in    = '0;
            src_port_in    = '0;
            pstart_in      = '0;
            seen_in        = '0;
            count_in       = '0;
            rsp_valid_in   = 1'b1;
            rsp_data_in.verdict     = verdict;
            rsp_data_in.appearances = (verdict == VERDICT_SELECTED) ? count_cur : '0;
         end else begin
            byte_offset_in = (byte_offset_ff != OFFSET_MAX) ?
                             byte_offset_ff + OFFSET_W'(1) : byte_offset_ff;
            ihb_in         = ihb_cur;
            proto_in       = proto_cur;
            src_addr_in    = src_addr_cur;
            src_port_in    = src_port_cur;
            pstart_in      = pstart_cur;
            seen_in        = take ? seen_new : seen_ff;
            count_in       = count_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_address_ff <= '0;
         match_port_ff    <= '0;
         pattern_ff       <= '0;
         pattern_len_ff   <= 4'd1;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_MATCH_ADDRESS: match_address_ff <= csr_wdata[31:0];
            CSR_MATCH_PORT:    match_port_ff    <= csr_wdata[15:0];
            CSR_PATTERN_BYTES: pattern_ff       <= csr_wdata;
            CSR_PATTERN_LEN:   pattern_len_ff   <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_offset_ff <= '0;
         ihb_ff         <= '0;
         proto_ff       <= '0;
         src_addr_ff    <= '0;
         src_port_ff    <= '0;
         pstart_ff      <= '0;
         seen_ff        <= '0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         byte_offset_ff <= byte_offset_in;
         ihb_ff         <= ihb_in;
         proto_ff       <= proto_in;
         src_addr_ff    <= src_addr_in;
         src_port_ff    <= src_port_in;
         pstart_ff      <= pstart_in;
         seen_ff        <= seen_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      recent_ff   <= recent_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_count_only_when_selected: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff.verdict == VERDICT_SELECTED) ==
                        (rsp_data_ff.appearances != '0)))
      else $error("appearances disagree with verdict");

   a_final_beat_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.end_of_packet) |=> (byte_offset_ff == '0 && seen_ff == '0
                                              && count_ff == '0 && pstart_ff == '0))
      else $error("packet state not cleared after final beat");

   a_final_beat_gives_result: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.end_of_packet) |=> rsp_valid_ff)
      else $error("final beat produced no result");

   a_seen_bounded: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= SEEN_MAX)
      else $error("payload byte tally beyond window");

   a_stall_only_on_full_slot: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid_ff && !rsp_ready))
      else $error("input stalled without a pending result");

endmodule

// ----- src/ippf_match.sv -----
// Pattern compare over the window of most recent payload bytes.
module ippf_match #(
   parameter int MAX_PATTERN = 8,
   parameter int SEEN_W      = $clog2(MAX_PATTERN + 1)
) (
   input  logic [MAX_PATTERN-1:0][7:0]      window,
   input  logic [SEEN_W-1:0]                seen,
   input  logic [SEEN_W-1:0]                pat_len,
   input  logic [ippf_pkg::PATTERN_W-1:0]   pattern,
   output logic                             hit
);
   import ippf_pkg::*;

   localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int EXT_W = 8 * MAX_PATTERN + PATTERN_W;

   logic [EXT_W-1:0] pat_ext;

   assign pat_ext = {{(8 * MAX_PATTERN){1'b0}}, pattern};

   always_comb begin
      logic              all_eq;
      logic [SEEN_W-1:0] pos;
      all_eq = 1'b1;
      for (int j = 0; j < MAX_PATTERN; j++) begin
         pos = pat_len - SEEN_W'(j) - SEEN_W'(1);
         if (SEEN_W'(j) < pat_len) begin
            if (pat_ext[8*j +: 8] != window[pos[IDX_W-1:0]]) begin
               all_eq = 1'b0;
            end
         end
      end
      hit = all_eq && (seen >= pat_len);
   end

endmodule

// ----- sim/tb_ip_packet_filter_pattern_count_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the IPv4 packet filter: per-packet verdicts and pattern counts.
module tb_ip_packet_filter_pattern_count_unit;
   import ippf_pkg::*;

   localparam int IDLE_LIMIT   = 20000;
   localparam int REPORT_LIMIT = 10;
   localparam int NO_CUT       = 0;

   typedef enum int {PAY_RANDOM, PAY_SEEDED, PAY_FROM_PATTERN} payload_kind_type;
   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MASK} rx_mode_type;

   logic                 clock        = 1'b0;
   logic                 reset        = 1'b1;
   logic                 req_valid    = 1'b0;
   logic                 req_ready;
   req_type              req_data     = '0;
   logic                 rsp_valid;
   logic                 rsp_ready    = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_write_en = 1'b0;
   logic [1:0]           csr_index    = '0;
   logic [PATTERN_W-1:0] csr_wdata    = '0;

   req_type byte_queue[$];
   rsp_type expected_verdicts[$];
   int      beats_queued   = 0;
   int      beats_accepted = 0;
   int      error_count    = 0;
   int      idle_cycles    = 0;
   bit      req_taken      = 1'b0;

   int          burst_left = 1;
   int          gap_left   = 0;
   int          rsp_tick   = 0;
   int          hold_left  = 0;
   int          mode_left  = 0;
   rx_mode_type rx_mode    = RX_OPEN;
   logic [7:0]  rx_mask    = 8'hFF;

   // filter registers as last written
   logic [31:0] sel_address = '0;
   logic [15:0] sel_port    = '0;
   logic [63:0] pat_bytes   = '0;
   logic [3:0]  pat_len     = 4'd1;

   // per-packet parse state
   logic [OFFSET_W-1:0] pkt_offset = '0;
   logic [IHB_W-1:0]    hdr_bytes  = '0;
   logic [7:0]          proto_seen = '0;
   logic [31:0]         src_addr   = '0;
   logic [15:0]         src_port   = '0;
   logic [PSTART_W-1:0] pay_start  = '0;
   logic [7:0]          recent [PATTERN_BYTES] = '{default: '0};
   logic [3:0]          pay_seen   = '0;
   logic [COUNT_W-1:0]  hit_count  = '0;

   ip_packet_filter_pattern_count_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic int eff_pattern_len();
      if (pat_len == 0) return 1;
      if (pat_len > PATTERN_BYTES) return PATTERN_BYTES;
      return pat_len;
   endfunction

   task automatic filter_step(input req_type beat, output bit done, output rsp_type res);
      logic [7:0] b;
      int         o, th, n, len, j, k;
      bit         hit;
      b = beat.pkt_byte;
      o = pkt_offset;
      done = 1'b0;
      res = '0;
      if (o == 0) begin
         hdr_bytes = {b[3:0], 2'b00};
         if (hdr_bytes < MIN_HDR_BYTES) hdr_bytes = MIN_HDR_BYTES;
      end
      if (o == OFS_PROTOCOL) begin
         proto_seen = b;
         if (b == PROTO_UDP) pay_start = hdr_bytes + UDP_HDR_BYTES;
      end
      if (o >= OFS_SRC_FIRST && o <= OFS_SRC_LAST) src_addr = {src_addr[23:0], b};
      if (o >= OFS_TRANSPORT) begin
         if (o == int'(hdr_bytes) || o == int'(hdr_bytes) + 1) src_port = {src_port[7:0], b};
         if (proto_seen == PROTO_TCP && o == int'(hdr_bytes) + int'(OFS_TCP_DOFF)) begin
            th = b[7:4] * 4;
            if (th < MIN_HDR_BYTES) th = MIN_HDR_BYTES;
            pay_start = PSTART_W'(int'(hdr_bytes) + th);
         end
      end
      if (pay_start != 0 && o >= int'(pay_start)) begin
         for (k = PATTERN_BYTES - 1; k > 0; k--) recent[k] = recent[k - 1];
         recent[0] = b;
         if (pay_seen < PATTERN_BYTES) pay_seen++;
         n = eff_pattern_len();
         if (pay_seen >= n) begin
            hit = 1'b1;
            for (j = 0; j < n; j++) begin
               if (pat_bytes[8 * j +: 8] != recent[n - 1 - j]) hit = 1'b0;
            end
            if (hit && hit_count != COUNT_MAX) hit_count++;
         end
      end
      if (pkt_offset != OFFSET_MAX) pkt_offset++;
      if (beat.end_of_packet) begin
         len = o + 1;
         done = 1'b1;
         if (len < MIN_HDR_BYTES) res.verdict = VERDICT_TRUNCATED;
         else if (src_addr != sel_address) res.verdict = VERDICT_ADDR_MISMATCH;
         else if (proto_seen != PROTO_TCP && proto_seen != PROTO_UDP)
            res.verdict = VERDICT_PROTO_PORT;
         else if (pay_start == 0 || len < int'(pay_start)) res.verdict = VERDICT_TRUNCATED;
         else if (src_port != sel_port) res.verdict = VERDICT_PROTO_PORT;
         else if (hit_count == 0) res.verdict = VERDICT_PATTERN_ABSENT;
         else begin
            res.verdict = VERDICT_SELECTED;
            res.appearances = hit_count;
         end
         pkt_offset = '0;
         hdr_bytes  = '0;
         proto_seen = '0;
         src_addr   = '0;
         src_port   = '0;
         pay_start  = '0;
         pay_seen   = '0;
         hit_count  = '0;
         for (k = 0; k < PATTERN_BYTES; k++) recent[k] = '0;
      end
   endtask

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("%0t mismatch: %s", $time, msg);
   endtask

   task automatic push_beat(input logic [7:0] b, input bit eop);
      byte_queue.push_back(req_type'{pkt_byte: b, end_of_packet: eop});
      beats_queued++;
   endtask

   task automatic queue_packet(input logic [3:0] ihl, input logic [7:0] proto,
         input logic [31:0] addr, input logic [15:0] port, input logic [3:0] doff,
         input int pay_len, input payload_kind_type kind, input int cut);
      logic [7:0] pkt[$];
      logic [7:0] b;
      int         ihb, th, n, p, total, i;
      ihb = (ihl < 5) ? 20 : ihl * 4;
      th = (proto == PROTO_TCP) ? ((doff < 5) ? 20 : doff * 4) : int'(UDP_HDR_BYTES);
      n = eff_pattern_len();
      for (i = 0; i < ihb; i++) begin
         b = $urandom;
         if (i == 0) b[3:0] = ihl;
         if (i == OFS_PROTOCOL) b = proto;
         if (i >= OFS_SRC_FIRST && i <= OFS_SRC_LAST) b = addr[8 * (int'(OFS_SRC_LAST) - i) +: 8];
         pkt.push_back(b);
      end
      for (i = 0; i < th; i++) begin
         b = $urandom;
         if (i == 0) b = port[15:8];
         if (i == 1) b = port[7:0];
         if (proto == PROTO_TCP && i == OFS_TCP_DOFF) b[7:4] = doff;
         pkt.push_back(b);
      end
      for (i = 0; i < pay_len; i++) begin
         b = $urandom;
         if (kind == PAY_FROM_PATTERN) b = pat_bytes[8 * $urandom_range(0, n - 1) +: 8];
         pkt.push_back(b);
      end
      if (kind == PAY_SEEDED) begin
         p = 0;
         while (p + n <= pay_len) begin
            if (p == 0 || $urandom_range(0, 5) == 0) begin
               for (i = 0; i < n; i++) pkt[ihb + th + p + i] = pat_bytes[8 * i +: 8];
               p += n;
            end else begin
               p++;
            end
         end
      end
      total = pkt.size();
      if (cut > 0 && cut < total) total = cut;
      for (i = 0; i < total; i++) push_beat(pkt[i], i == total - 1);
   endtask

   task automatic queue_random_packet();
      int          pick, len, i;
      logic [3:0]  ihl, doff;
      logic [7:0]  proto;
      logic [31:0] addr;
      logic [15:0] port;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         len = $urandom_range(1, 60);
         for (i = 0; i < len; i++) push_beat(8'($urandom), i == len - 1);
      end else begin
         ihl = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'd5;
         pick = $urandom_range(0, 99);
         proto = (pick < 45) ? PROTO_TCP : (pick < 80) ? PROTO_UDP : 8'($urandom);
         addr = ($urandom_range(0, 4) == 0) ? 32'($urandom) : sel_address;
         port = ($urandom_range(0, 4) == 0) ? 16'($urandom) : sel_port;
         doff = ($urandom_range(0, 6) == 0) ? 4'($urandom) : 4'd5;
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 100) : $urandom_range(0, 40);
         queue_packet(ihl, proto, addr, port, doff, len,
                      payload_kind_type'($urandom_range(0, 2)),
                      ($urandom_range(0, 9) == 0) ? $urandom_range(1, 80) : NO_CUT);
      end
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [PATTERN_W-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_MATCH_ADDRESS: sel_address = value[31:0];
         CSR_MATCH_PORT:    sel_port = value[15:0];
         CSR_PATTERN_BYTES: pat_bytes = value;
         CSR_PATTERN_LEN:   pat_len = value[3:0];
         default: begin
         end
      endcase
   endtask

   task automatic program_filter(input logic [31:0] addr, input logic [15:0] port,
         input logic [63:0] pat_value, input logic [3:0] len);
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      write_reg(CSR_MATCH_ADDRESS, {junk[63:32], addr});
      write_reg(CSR_MATCH_PORT, {junk[63:16], port});
      write_reg(CSR_PATTERN_BYTES, pat_value);
      write_reg(CSR_PATTERN_LEN, {junk[63:4], len});
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (beats_accepted != beats_queued || expected_verdicts.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   always @(negedge clock) begin : sender
      logic next_valid;
      next_valid = req_valid && !req_taken;
      if (!next_valid) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (byte_queue.size() > 0) begin
            req_data <= byte_queue.pop_front();
            next_valid = 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 64);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
      end
      req_valid <= next_valid;
   end

   always @(negedge clock) begin : receiver
      logic next_ready;
      rsp_tick++;
      // hold off long enough for the result slot to back up the byte stream
      if (hold_left == 0 && (rsp_tick % 1024 == 0 || $urandom_range(0, 2999) == 0))
         hold_left = $urandom_range(200, 400);
      if (hold_left > 0) begin
         hold_left--;
         next_ready = 1'b0;
      end else begin
         if (mode_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(32, 256);
            rx_mask = 8'($urandom) | 8'h01;
         end else begin
            mode_left--;
         end
         case (rx_mode)
            RX_OPEN:   next_ready = 1'b1;
            RX_COIN:   next_ready = $urandom_range(0, 1);
            RX_SPARSE: next_ready = ($urandom_range(0, 7) == 0);
            RX_MASK: begin
               next_ready = rx_mask[0];
               rx_mask = {rx_mask[0], rx_mask[7:1]};
            end
            default:   next_ready = 1'b1;
         endcase
      end
      rsp_ready <= next_ready;
   end

   always @(posedge clock) begin : monitor
      rsp_type want;
      rsp_type predicted;
      bit      produced;
      bit      rsp_taken;
      bit      useful;
      useful = 1'b0;
      req_taken = req_valid && req_ready;
      rsp_taken = (rsp_valid === 1'b1) && rsp_ready;
      if (rsp_taken) begin
         if (expected_verdicts.size() == 0) begin
            flag_error($sformatf("unexpected result: verdict %0d appearances %0d",
                                 rsp_data.verdict, rsp_data.appearances));
         end else begin
            want = expected_verdicts.pop_front();
            useful = 1'b1;
            if (rsp_data.verdict !== want.verdict)
               flag_error($sformatf("verdict expected %s got %0d",
                                    want.verdict.name(), rsp_data.verdict));
            if (rsp_data.appearances !== want.appearances)
               flag_error($sformatf("appearances expected %0d got %0d",
                                    want.appearances, rsp_data.appearances));
         end
      end
      if (req_taken) begin
         beats_accepted++;
         filter_step(req_data, produced, predicted);
         if (produced) expected_verdicts.push_back(predicted);
      end
      if (req_taken || useful) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      logic [31:0] addr_a;
      logic [15:0] port_a;
      logic [7:0]  fill;
      int          ph, phase_start, packets;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // registers at their reset values
      queue_packet(4'd5, PROTO_UDP, 32'd0, 16'd0, 4'd5, 4, PAY_FROM_PATTERN, NO_CUT);
      queue_packet(4'd5, PROTO_UDP, 32'd0, 16'd0, 4'd5, 4, PAY_RANDOM, 1);
      queue_packet(4'd5, PROTO_UDP, 32'd0, 16'd0, 4'd5, 4, PAY_RANDOM, 19);
      queue_packet(4'd5, 8'd1, 32'd0, 16'd0, 4'd5, 4, PAY_RANDOM, 20);
      wait_drained();

      addr_a = 32'hC0A8_0001;
      port_a = 16'd8080;
      program_filter(addr_a, port_a, 64'h2054_4547, 4'd4);
      queue_packet(4'd5, PROTO_TCP, addr_a, port_a, 4'd5, 30, PAY_SEEDED, NO_CUT);
      queue_packet(4'd5, PROTO_TCP, ~addr_a, port_a, 4'd5, 10, PAY_SEEDED, NO_CUT);
      queue_packet(4'd5, 8'd1, addr_a, port_a, 4'd5, 10, PAY_SEEDED, NO_CUT);
      queue_packet(4'd5, 8'hFF, addr_a, port_a, 4'd5, 0, PAY_RANDOM, NO_CUT);
      queue_packet(4'd5, PROTO_TCP, addr_a, port_a, 4'd5, 10, PAY_SEEDED, 30);
      queue_packet(4'd5, PROTO_TCP, addr_a, port_a, 4'd5, 10, PAY_SEEDED, 36);
      queue_packet(4'd5, PROTO_UDP, addr_a, ~port_a, 4'd5, 10, PAY_SEEDED, NO_CUT);
      queue_packet(4'd5, PROTO_UDP, addr_a, port_a, 4'd5, 10, PAY_RANDOM, NO_CUT);
      queue_packet(4'd5, PROTO_UDP, addr_a, port_a, 4'd5, 0, PAY_RANDOM, NO_CUT);
      queue_packet(4'd2, PROTO_TCP, addr_a, port_a, 4'd5, 12, PAY_SEEDED, NO_CUT);
      queue_packet(4'd15, PROTO_UDP, addr_a, port_a, 4'd5, 8, PAY_SEEDED, NO_CUT);
      queue_packet(4'd5, PROTO_TCP, addr_a, port_a, 4'd3, 8, PAY_SEEDED, NO_CUT);
      queue_packet(4'd0, PROTO_TCP, addr_a, port_a, 4'd15, 8, PAY_SEEDED, NO_CUT);
      queue_packet(4'd5, PROTO_UDP, addr_a, port_a, 4'd5, 4, PAY_SEEDED, 19);
      queue_packet(4'd5, PROTO_UDP, addr_a, port_a, 4'd5, 4, PAY_SEEDED, 1);
      wait_drained();

      // overlapping matches
      program_filter('1, '1, {8{8'h41}}, 4'd3);
      queue_packet(4'd5, PROTO_UDP, '1, '1, 4'd5, 12, PAY_FROM_PATTERN, NO_CUT);
      queue_packet(4'd5, PROTO_TCP, '1, '1, 4'd5, 9, PAY_FROM_PATTERN, NO_CUT);
      wait_drained();

      for (ph = 0; ph < 8; ph++) begin
         fill = $urandom;
         case (ph)
            0: program_filter('0, '0, '0, 4'd1);
            1: program_filter('1, '1, '1, 4'd8);
            2: program_filter($urandom, 16'($urandom), {$urandom, $urandom}, 4'd0);
            3: program_filter($urandom, 16'($urandom), {8{fill}}, 4'd15);
            default: program_filter($urandom, 16'($urandom),
                        ($urandom_range(0, 1) == 0) ? {8{fill}} : {$urandom, $urandom},
                        4'($urandom));
         endcase
         phase_start = beats_queued;
         packets = 0;
         while (beats_queued - phase_start < 90 || packets < 4) begin
            queue_random_packet();
            packets++;
         end
         wait_drained();
      end

      repeat (8) @(negedge clock);
      if (error_count == 0 && expected_verdicts.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- ip_packet_filter_pattern_count_unit.f -----
src/ippf_pkg.sv
src/ippf_match.sv
src/ip_packet_filter_pattern_count_unit.sv
sim/tb_ip_packet_filter_pattern_count_unit.sv
